[sv/grd_pkg.sv]
package grd_pkg;

	localparam int MAX_ROW_BYTES = 1024;
	localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
	localparam int COL_W = $clog2(MAX_ROW_BYTES + 1);
	localparam int ROWB_W = 11;
	localparam int MODE_W = 2;
	localparam int NIB_W = 4;
	localparam int CNT_W = 4;
	localparam int MAX_RESULTS = 9;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;
	localparam int RUN_BIAS = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_RAW = 2'd0;
	localparam mode_t MODE_PACK = 2'd1;
	localparam mode_t MODE_RLE = 2'd2;

	localparam logic REG_ROW_BYTES = 1'b0;
	localparam logic REG_MODE = 1'b1;

	function automatic logic [2*NIB_W-1:0] dup_nibble(input logic [NIB_W-1:0] v);
		return {v, v};
	endfunction

endpackage

[sv/glyph_rle4_delta_decoder.sv]
// Glyph row decoder: compressed glyph bytes in, 8-bit coverage pixels out.
// Input channel (code_byte, glyph_start, in_valid/in_ready) takes one word per
// accepted byte; output channel (pixel, row_end, last, format_error,
// out_valid/out_ready) gives 0 to 9 words per byte, last set on the final one.
// Config: APB write row_bytes at 0x0, decode_mode at 0x4, only while idle.
// Sequence: a byte is taken, then each pixel passes a read step (line store
// read) and an emit step (add and write back through the one nibble adder,
// load the output register); emit waits while the output word is not taken.
// A byte with no pixels leaves the sequencer idle. in_ready is low while a
// byte's pixels are being produced.
// The output register holds a finished pixel; the next byte is taken while the
// last pixel of the previous one still waits. A stalled receiver holds the
// sequencer in its emit step; nothing is lost.
// Reset: row_bytes 1, decode_mode 2 (RLE4 delta), row zero, column zero. The
// line store is not cleared; it is written row by row before it is read.
module glyph_rle4_delta_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [grd_pkg::PADDR_W-1:0] paddr,
	input  logic [grd_pkg::PDATA_W-1:0] pwdata,
	output logic [grd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic [7:0]                  code_byte,
	input  logic                        glyph_start,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic [7:0]                  pixel,
	output logic                        row_end,
	output logic                        last,
	output logic                        format_error,
	output logic                        out_valid,
	input  logic                        out_ready
);

	import grd_pkg::*;

	logic [ROWB_W-1:0] row_bytes_q;
	mode_t             mode_q;

	state_t state_q, state_d;

	logic [COL_W-1:0] column_q;
	logic             first_row_q;
	logic [2:0]       lit_left_q;
	logic             trunc_q;
	logic [CNT_W-1:0] cnt_q;

	logic [7:0] byte_q;
	logic       sel_hi_q;
	logic       delta_q;
	logic       raw_q;
	logic       err_q;

	logic       out_valid_q;
	logic [7:0] pixel_q;
	logic       row_end_q;
	logic       last_q;
	logic       format_error_q;

	logic [COL_W-1:0] w;
	logic             accept;
	logic             load_out;
	logic             ram_re;
	logic             cfg_wr;

	logic [COL_W-1:0] acc_col;
	logic             acc_first;
	logic [2:0]       acc_lit;
	logic             acc_trunc;
	logic [CNT_W-1:0] acc_cnt;
	logic             acc_sel_hi;
	logic             acc_delta;
	logic             acc_raw;
	logic             acc_err;

	logic [NIB_W-1:0] ram_rdata;
	logic [NIB_W-1:0] nib;
	logic [NIB_W-1:0] above;
	logic [NIB_W-1:0] val;
	logic [7:0]       pix;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROWB_W'(1);
			mode_q <= MODE_RLE;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ROW_BYTES: row_bytes_q <= pwdata[ROWB_W-1:0];
				REG_MODE: mode_q <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROW_BYTES: prdata = PDATA_W'(row_bytes_q);
			REG_MODE: prdata = PDATA_W'(mode_q);
			default: prdata = '0;
		endcase
	end

	// effective row width
	always_comb begin
		if (row_bytes_q == '0) begin
			w = COL_W'(1);
		end else if (32'(row_bytes_q) > 32'(MAX_ROW_BYTES)) begin
			w = COL_W'(MAX_ROW_BYTES);
		end else begin
			w = COL_W'(row_bytes_q);
		end
	end

	// header decode at accept
	always_comb begin
		logic [COL_W-1:0] remaining;
		logic [2:0]       k;
		logic [3:0]       len;
		logic [3:0]       total;
		acc_col = glyph_start ? '0 : column_q;
		acc_first = glyph_start ? 1'b1 : first_row_q;
		acc_lit = glyph_start ? 3'd0 : lit_left_q;
		acc_trunc = glyph_start ? 1'b0 : trunc_q;
		acc_cnt = '0;
		acc_sel_hi = 1'b0;
		acc_delta = 1'b0;
		acc_raw = 1'b0;
		acc_err = 1'b0;
		remaining = '0;
		k = code_byte[6:4];
		len = {1'b0, k} + 4'(RUN_BIAS);
		total = {k, 1'b1};
		case (mode_q)
			MODE_RAW, MODE_PACK: begin
				acc_lit = 3'd0;
				if (acc_col >= w) begin
					acc_col = '0;
					acc_first = 1'b0;
				end
				if (mode_q == MODE_RAW) begin
					acc_cnt = CNT_W'(1);
					acc_raw = 1'b1;
				end else if (acc_col + COL_W'(1) == w) begin
					acc_cnt = CNT_W'(1);
				end else begin
					acc_cnt = CNT_W'(2);
					acc_sel_hi = 1'b1;
				end
			end
			MODE_RLE: begin
				acc_delta = 1'b1;
				if (acc_lit != 3'd0) begin
					// literal continuation, high nibble first
					acc_lit = acc_lit - 3'd1;
					acc_err = acc_trunc;
					acc_sel_hi = 1'b1;
					if (acc_col < w) begin
						acc_cnt = (w - acc_col >= COL_W'(2)) ? CNT_W'(2) : CNT_W'(1);
					end
				end else begin
					if (acc_col >= w) begin
						acc_col = '0;
						acc_first = 1'b0;
					end
					remaining = w - acc_col;
					if (code_byte[7]) begin
						if (COL_W'(len) > remaining) begin
							acc_err = 1'b1;
							acc_cnt = CNT_W'(remaining);
						end else begin
							acc_cnt = len;
						end
					end else begin
						acc_trunc = (COL_W'(total) > remaining + COL_W'(1));
						acc_lit = k;
						acc_cnt = CNT_W'(1);
						acc_err = acc_trunc;
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_re = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && acc_cnt != '0) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_re = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			first_row_q <= 1'b1;
			lit_left_q <= '0;
			trunc_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			column_q <= acc_col;
			first_row_q <= acc_first;
			lit_left_q <= acc_lit;
			trunc_q <= acc_trunc;
			cnt_q <= acc_cnt;
		end else if (load_out) begin
			column_q <= column_q + COL_W'(1);
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= code_byte;
			sel_hi_q <= acc_sel_hi;
			delta_q <= acc_delta;
			raw_q <= acc_raw;
			err_q <= acc_err;
		end else if (load_out) begin
			sel_hi_q <= 1'b0;
		end
	end

	// shared nibble adder
	assign nib = sel_hi_q ? byte_q[7:4] : byte_q[3:0];
	assign above = first_row_q ? '0 : ram_rdata;
	assign val = delta_q ? (above + nib) : nib;
	assign pix = raw_q ? byte_q : dup_nibble(val);

	grd_ram #(
		.WIDTH(NIB_W),
		.DEPTH(MAX_ROW_BYTES)
	) u_line_store (
		.clk(clk),
		.we(load_out),
		.re(ram_re),
		.addr(column_q[ADDR_W-1:0]),
		.wdata(pix[NIB_W-1:0]),
		.rdata(ram_rdata)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_q <= pix;
			row_end_q <= (column_q + COL_W'(1) == w);
			last_q <= (cnt_q == CNT_W'(1));
			format_error_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel = pixel_q;
	assign row_end = row_end_q;
	assign last = last_q;
	assign format_error = format_error_q;

`ifndef NO_ASSERTIONS
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (column_q < w))
		else $error("emit column past row width");

	a_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cnt_q != '0 && cnt_q <= CNT_W'(MAX_RESULTS)))
		else $error("pixel count out of range while busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && cnt_q == CNT_W'(1)) |=> (state_q == ST_IDLE && last_q))
		else $error("final pixel did not end the byte");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_EMIT))
		else $error("read step not followed by emit");
`endif

endmodule

[sv/grd_ram.sv]
module grd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
